// ===== hdl/rtch_pkg.sv =====
// Shared types, constants and the multiply program of the closest-hit unit.
package rtch_pkg;

    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int INDEX_BITS = 24;

    localparam int DIST_BITS = COORD_BITS - 1;
    localparam int BARY_BITS = FRAC_BITS + 1;
    localparam int NB        = COORD_BITS + 1;
    localparam int WW        = 4 * COORD_BITS + 4;

    localparam int IN_BITS     = 9 * COORD_BITS + INDEX_BITS + DIST_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = 2 + INDEX_BITS + DIST_BITS + 2 * BARY_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int IN_INDEX_LSB = 9 * COORD_BITS;
    localparam int IN_LIMIT_LSB = IN_INDEX_LSB + INDEX_BITS;

    localparam int OUT_FOUND_LSB = 0;
    localparam int OUT_TRI_LSB   = 1;
    localparam int OUT_DIST_LSB  = OUT_TRI_LSB + INDEX_BITS;
    localparam int OUT_U_LSB     = OUT_DIST_LSB + DIST_BITS;
    localparam int OUT_V_LSB     = OUT_U_LSB + BARY_BITS;
    localparam int OUT_REPL_LSB  = OUT_V_LSB + BARY_BITS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int MCNT_W = $clog2(NB);
    localparam int QB_W   = $clog2(COORD_BITS);
    localparam int STEP_W = 5;

    localparam logic [STEP_W-1:0] LAST_CALC_STEP = STEP_W'(23);
    localparam logic [STEP_W-1:0] LIM_STEP       = STEP_W'(24);

    typedef enum logic {
        MODE_RAY = 1'b0,
        MODE_TRI = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                          mode;
        logic [2:0][COORD_BITS-1:0]     vec_a;
        logic [2:0][COORD_BITS-1:0]     vec_b;
        logic [2:0][COORD_BITS-1:0]     vec_c;
        logic [INDEX_BITS-1:0]          tri_index;
        logic [DIST_BITS-1:0]           start_limit;
    } item_t;

    typedef enum logic [3:0] {
        A_E1_0, A_E1_1, A_E1_2, A_E2_0, A_E2_1, A_E2_2,
        A_PV0, A_PV1, A_PV2, A_QV0, A_QV1, A_QV2, A_DET
    } a_src_t;

    typedef enum logic [3:0] {
        B_D0, B_D1, B_D2, B_E1_0, B_E1_1, B_E1_2, B_E2_0, B_E2_1, B_E2_2,
        B_TV0, B_TV1, B_TV2, B_BEST
    } b_src_t;

    typedef enum logic [3:0] {
        W_PV0, W_PV1, W_PV2, W_QV0, W_QV1, W_QV2,
        W_DET, W_UN, W_VN, W_TN, W_LIM
    } dst_t;

    typedef enum logic [1:0] {
        OP_SET, OP_ADD, OP_SUB
    } acc_op_t;

    typedef struct packed {
        a_src_t  a;
        b_src_t  b;
        dst_t    dst;
        acc_op_t op;
    } uop_t;

    typedef enum logic [1:0] {
        DV_T, DV_U, DV_V
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_GO, ST_MUL_WAIT, ST_NORM, ST_CHECK, ST_CMP,
        ST_DIV_GO, ST_DIV_WAIT, ST_RESULT
    } back_state_t;

    typedef struct packed {
        logic pop;
        logic mul_start;
        logic div_start;
        logic out_load;
    } back_ctrl_t;

    // Products of the cross and dot products, then the limit product.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        unique case (step)
            5'd0:    u = '{A_E2_2, B_D1,   W_PV0, OP_SET};
            5'd1:    u = '{A_E2_1, B_D2,   W_PV0, OP_SUB};
            5'd2:    u = '{A_E2_0, B_D2,   W_PV1, OP_SET};
            5'd3:    u = '{A_E2_2, B_D0,   W_PV1, OP_SUB};
            5'd4:    u = '{A_E2_1, B_D0,   W_PV2, OP_SET};
            5'd5:    u = '{A_E2_0, B_D1,   W_PV2, OP_SUB};
            5'd6:    u = '{A_PV0,  B_E1_0, W_DET, OP_SET};
            5'd7:    u = '{A_PV1,  B_E1_1, W_DET, OP_ADD};
            5'd8:    u = '{A_PV2,  B_E1_2, W_DET, OP_ADD};
            5'd9:    u = '{A_PV0,  B_TV0,  W_UN,  OP_SET};
            5'd10:   u = '{A_PV1,  B_TV1,  W_UN,  OP_ADD};
            5'd11:   u = '{A_PV2,  B_TV2,  W_UN,  OP_ADD};
            5'd12:   u = '{A_E1_2, B_TV1,  W_QV0, OP_SET};
            5'd13:   u = '{A_E1_1, B_TV2,  W_QV0, OP_SUB};
            5'd14:   u = '{A_E1_0, B_TV2,  W_QV1, OP_SET};
            5'd15:   u = '{A_E1_2, B_TV0,  W_QV1, OP_SUB};
            5'd16:   u = '{A_E1_1, B_TV0,  W_QV2, OP_SET};
            5'd17:   u = '{A_E1_0, B_TV1,  W_QV2, OP_SUB};
            5'd18:   u = '{A_QV0,  B_D0,   W_VN,  OP_SET};
            5'd19:   u = '{A_QV1,  B_D1,   W_VN,  OP_ADD};
            5'd20:   u = '{A_QV2,  B_D2,   W_VN,  OP_ADD};
            5'd21:   u = '{A_QV0,  B_E2_0, W_TN,  OP_SET};
            5'd22:   u = '{A_QV1,  B_E2_1, W_TN,  OP_ADD};
            5'd23:   u = '{A_QV2,  B_E2_2, W_TN,  OP_ADD};
            default: u = '{A_DET,  B_BEST, W_LIM, OP_SET};
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/rtch_front.sv =====
// Input stage: unpacks beats and queues them for the sequencer.
module rtch_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rtch_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    output rtch_pkg::item_t                  item,
    output logic                             item_valid,
    input  logic                             item_pop
);

    rtch_pkg::item_t                  mem_reg [rtch_pkg::QUEUE_DEPTH];
    rtch_pkg::item_t                  in_item;
    logic [rtch_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [rtch_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [rtch_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             push;
    logic                             pop;

    always_comb begin
        in_item.mode = rtch_pkg::mode_t'(s_tuser);
        for (int k = 0; k < 3; k++) begin
            in_item.vec_a[k] = s_tdata[k*rtch_pkg::COORD_BITS +: rtch_pkg::COORD_BITS];
            in_item.vec_b[k] = s_tdata[(3+k)*rtch_pkg::COORD_BITS +: rtch_pkg::COORD_BITS];
            in_item.vec_c[k] = s_tdata[(6+k)*rtch_pkg::COORD_BITS +: rtch_pkg::COORD_BITS];
        end
        in_item.tri_index   = s_tdata[rtch_pkg::IN_INDEX_LSB +: rtch_pkg::INDEX_BITS];
        in_item.start_limit = s_tdata[rtch_pkg::IN_LIMIT_LSB +: rtch_pkg::DIST_BITS];
    end

    assign s_tready   = (count_reg != rtch_pkg::QCNT_W'(rtch_pkg::QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pop        = item_pop && item_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == rtch_pkg::QPTR_W'(rtch_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == rtch_pkg::QPTR_W'(rtch_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hdl/rtch_mul.sv =====
// Shift-add signed multiplier, one multiplier bit per cycle.
module rtch_mul (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic signed [rtch_pkg::WW-1:0] a,
    input  logic signed [rtch_pkg::NB-1:0] b,
    output logic                           done,
    output logic signed [rtch_pkg::WW-1:0] p
);

    localparam logic [rtch_pkg::MCNT_W-1:0] LAST = rtch_pkg::MCNT_W'(rtch_pkg::NB - 1);

    logic signed [rtch_pkg::WW-1:0] acc_reg;
    logic signed [rtch_pkg::WW-1:0] ash_reg;
    logic        [rtch_pkg::NB-1:0] bsh_reg;
    logic [rtch_pkg::MCNT_W-1:0]    cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    assign done = done_reg;
    assign p    = acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == LAST) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // The top bit of b carries negative weight.
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg <= '0;
            ash_reg <= a;
            bsh_reg <= b;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            if (bsh_reg[0]) begin
                acc_reg <= (cnt_reg == LAST) ? acc_reg - ash_reg : acc_reg + ash_reg;
            end
            ash_reg <= ash_reg <<< 1;
            bsh_reg <= bsh_reg >> 1;
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

// ===== hdl/rtch_div.sv =====
// Restoring divider for non-negative operands, one quotient bit per cycle.
module rtch_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [rtch_pkg::WW-1:0]             num,
    input  logic [rtch_pkg::WW-1:0]             den,
    input  logic [rtch_pkg::QB_W-1:0]           qbits,
    output logic                                done,
    output logic [rtch_pkg::DIST_BITS-1:0]      quo
);

    logic [rtch_pkg::WW-1:0]        rem_reg;
    logic [rtch_pkg::WW-1:0]        dsh_reg;
    logic [rtch_pkg::DIST_BITS-1:0] q_reg;
    logic [rtch_pkg::QB_W-1:0]      cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic                           ge;

    assign ge   = (rem_reg >= dsh_reg);
    assign done = done_reg;
    assign quo  = q_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == '0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= den << (qbits - 1'b1);
            cnt_reg <= qbits - 1'b1;
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[rtch_pkg::DIST_BITS-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

// ===== hdl/rtch_back.sv =====
// Sequencer: ray state, intersection arithmetic, closest-hit update and result register.
module rtch_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  rtch_pkg::item_t                   item,
    input  logic                              item_valid,
    output logic                              item_pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rtch_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int C  = rtch_pkg::COORD_BITS;
    localparam int F  = rtch_pkg::FRAC_BITS;
    localparam int W  = rtch_pkg::WW;
    localparam int NB = rtch_pkg::NB;

    localparam logic [rtch_pkg::QB_W-1:0] T_QBITS = rtch_pkg::QB_W'(rtch_pkg::DIST_BITS);
    localparam logic [rtch_pkg::QB_W-1:0] B_QBITS = rtch_pkg::QB_W'(rtch_pkg::BARY_BITS);

    rtch_pkg::back_state_t state_reg, state_next;
    rtch_pkg::back_ctrl_t  ctrl;
    rtch_pkg::uop_t        uop;
    rtch_pkg::div_sel_t    div_sel_reg;

    logic signed [C-1:0]  ray_o_reg [3];
    logic signed [C-1:0]  ray_d_reg [3];
    logic signed [C-1:0]  e1_reg [3];
    logic signed [C-1:0]  e2_reg [3];
    logic signed [NB-1:0] tv_reg [3];
    logic [rtch_pkg::INDEX_BITS-1:0] index_reg;

    logic signed [W-1:0] pv_reg [3];
    logic signed [W-1:0] qv_reg [3];
    logic signed [W-1:0] det_reg, un_reg, vn_reg, tn_reg, lim_reg;

    logic [rtch_pkg::DIST_BITS-1:0]  best_dist_reg;
    logic [rtch_pkg::INDEX_BITS-1:0] best_tri_reg;
    logic [rtch_pkg::BARY_BITS-1:0]  best_u_reg, best_v_reg;
    logic                            any_hit_reg;
    logic                            replaced_reg;
    logic [rtch_pkg::STEP_W-1:0]     step_reg;

    logic                            out_valid_reg;
    logic [rtch_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic signed [W-1:0]  mul_a, mul_p, cur, acc_val, tsc;
    logic signed [NB-1:0] mul_b;
    logic                 mul_done;
    logic [W-1:0]         div_num;
    logic [rtch_pkg::QB_W-1:0] div_qbits;
    logic                 div_done;
    logic [rtch_pkg::DIST_BITS-1:0] div_q;
    logic                 in_range;
    logic                 out_free;

    assign uop      = rtch_pkg::uop_at(step_reg);
    assign tsc      = tn_reg <<< F;
    assign out_free = !out_valid_reg || m_tready;
    assign in_range = !un_reg[W-1] && (un_reg <= det_reg) && !vn_reg[W-1] &&
                      ((un_reg + vn_reg) <= det_reg) && !tn_reg[W-1];

    always_comb begin
        case (uop.a)
            rtch_pkg::A_E1_0: mul_a = W'(e1_reg[0]);
            rtch_pkg::A_E1_1: mul_a = W'(e1_reg[1]);
            rtch_pkg::A_E1_2: mul_a = W'(e1_reg[2]);
            rtch_pkg::A_E2_0: mul_a = W'(e2_reg[0]);
            rtch_pkg::A_E2_1: mul_a = W'(e2_reg[1]);
            rtch_pkg::A_E2_2: mul_a = W'(e2_reg[2]);
            rtch_pkg::A_PV0:  mul_a = pv_reg[0];
            rtch_pkg::A_PV1:  mul_a = pv_reg[1];
            rtch_pkg::A_PV2:  mul_a = pv_reg[2];
            rtch_pkg::A_QV0:  mul_a = qv_reg[0];
            rtch_pkg::A_QV1:  mul_a = qv_reg[1];
            rtch_pkg::A_QV2:  mul_a = qv_reg[2];
            default:          mul_a = det_reg;
        endcase
        case (uop.b)
            rtch_pkg::B_D0:   mul_b = NB'(ray_d_reg[0]);
            rtch_pkg::B_D1:   mul_b = NB'(ray_d_reg[1]);
            rtch_pkg::B_D2:   mul_b = NB'(ray_d_reg[2]);
            rtch_pkg::B_E1_0: mul_b = NB'(e1_reg[0]);
            rtch_pkg::B_E1_1: mul_b = NB'(e1_reg[1]);
            rtch_pkg::B_E1_2: mul_b = NB'(e1_reg[2]);
            rtch_pkg::B_E2_0: mul_b = NB'(e2_reg[0]);
            rtch_pkg::B_E2_1: mul_b = NB'(e2_reg[1]);
            rtch_pkg::B_E2_2: mul_b = NB'(e2_reg[2]);
            rtch_pkg::B_TV0:  mul_b = tv_reg[0];
            rtch_pkg::B_TV1:  mul_b = tv_reg[1];
            rtch_pkg::B_TV2:  mul_b = tv_reg[2];
            default:          mul_b = $signed(NB'(best_dist_reg));
        endcase
        case (uop.dst)
            rtch_pkg::W_PV0: cur = pv_reg[0];
            rtch_pkg::W_PV1: cur = pv_reg[1];
            rtch_pkg::W_PV2: cur = pv_reg[2];
            rtch_pkg::W_QV0: cur = qv_reg[0];
            rtch_pkg::W_QV1: cur = qv_reg[1];
            rtch_pkg::W_QV2: cur = qv_reg[2];
            rtch_pkg::W_DET: cur = det_reg;
            rtch_pkg::W_UN:  cur = un_reg;
            rtch_pkg::W_VN:  cur = vn_reg;
            rtch_pkg::W_TN:  cur = tn_reg;
            default:         cur = lim_reg;
        endcase
        case (uop.op)
            rtch_pkg::OP_ADD: acc_val = cur + mul_p;
            rtch_pkg::OP_SUB: acc_val = cur - mul_p;
            default:          acc_val = mul_p;
        endcase
        case (div_sel_reg)
            rtch_pkg::DV_T: begin
                div_num   = tsc;
                div_qbits = T_QBITS;
            end
            rtch_pkg::DV_U: begin
                div_num   = un_reg <<< F;
                div_qbits = B_QBITS;
            end
            default: begin
                div_num   = vn_reg <<< F;
                div_qbits = B_QBITS;
            end
        endcase
    end

    rtch_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .p       (mul_p)
    );

    rtch_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (div_num),
        .den     (det_reg),
        .qbits   (div_qbits),
        .done    (div_done),
        .quo     (div_q)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            rtch_pkg::ST_IDLE: begin
                if (item_valid) begin
                    state_next = (item.mode == rtch_pkg::MODE_RAY) ?
                                 rtch_pkg::ST_RESULT : rtch_pkg::ST_MUL_GO;
                end
            end
            rtch_pkg::ST_MUL_GO: state_next = rtch_pkg::ST_MUL_WAIT;
            rtch_pkg::ST_MUL_WAIT: begin
                if (mul_done) begin
                    if (step_reg == rtch_pkg::LIM_STEP) begin
                        state_next = rtch_pkg::ST_CMP;
                    end else if (step_reg == rtch_pkg::LAST_CALC_STEP) begin
                        state_next = rtch_pkg::ST_NORM;
                    end else begin
                        state_next = rtch_pkg::ST_MUL_GO;
                    end
                end
            end
            rtch_pkg::ST_NORM: begin
                state_next = (det_reg == '0) ? rtch_pkg::ST_RESULT : rtch_pkg::ST_CHECK;
            end
            rtch_pkg::ST_CHECK: begin
                state_next = in_range ? rtch_pkg::ST_MUL_GO : rtch_pkg::ST_RESULT;
            end
            rtch_pkg::ST_CMP: begin
                state_next = (tsc <= lim_reg) ? rtch_pkg::ST_DIV_GO : rtch_pkg::ST_RESULT;
            end
            rtch_pkg::ST_DIV_GO: state_next = rtch_pkg::ST_DIV_WAIT;
            rtch_pkg::ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = (div_sel_reg == rtch_pkg::DV_V) ?
                                 rtch_pkg::ST_RESULT : rtch_pkg::ST_DIV_GO;
                end
            end
            rtch_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = rtch_pkg::ST_IDLE;
                end
            end
            default: state_next = rtch_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            rtch_pkg::ST_IDLE:   ctrl.pop       = item_valid;
            rtch_pkg::ST_MUL_GO: ctrl.mul_start = 1'b1;
            rtch_pkg::ST_DIV_GO: ctrl.div_start = 1'b1;
            rtch_pkg::ST_RESULT: ctrl.out_load  = out_free;
            default:             ctrl = '0;
        endcase
    end

    assign item_pop = ctrl.pop;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rtch_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            best_dist_reg <= '0;
            best_tri_reg  <= '0;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            any_hit_reg   <= 1'b0;
            replaced_reg  <= 1'b0;
            step_reg      <= '0;
            div_sel_reg   <= rtch_pkg::DV_T;
            for (int k = 0; k < 3; k++) begin
                ray_o_reg[k] <= '0;
                ray_d_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (ctrl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (ctrl.pop) begin
                replaced_reg <= 1'b0;
                step_reg     <= '0;
                if (item.mode == rtch_pkg::MODE_RAY) begin
                    for (int k = 0; k < 3; k++) begin
                        ray_o_reg[k] <= item.vec_a[k];
                        ray_d_reg[k] <= item.vec_b[k];
                    end
                    best_dist_reg <= item.start_limit;
                    best_tri_reg  <= '0;
                    best_u_reg    <= '0;
                    best_v_reg    <= '0;
                    any_hit_reg   <= 1'b0;
                end
            end
            if (state_reg == rtch_pkg::ST_MUL_WAIT && mul_done &&
                step_reg != rtch_pkg::LAST_CALC_STEP && step_reg != rtch_pkg::LIM_STEP) begin
                step_reg <= step_reg + 1'b1;
            end
            if (state_reg == rtch_pkg::ST_CHECK) begin
                step_reg <= rtch_pkg::LIM_STEP;
            end
            if (state_reg == rtch_pkg::ST_CMP) begin
                div_sel_reg <= rtch_pkg::DV_T;
            end
            if (state_reg == rtch_pkg::ST_DIV_WAIT && div_done) begin
                case (div_sel_reg)
                    rtch_pkg::DV_T: begin
                        best_dist_reg <= div_q;
                        div_sel_reg   <= rtch_pkg::DV_U;
                    end
                    rtch_pkg::DV_U: begin
                        best_u_reg  <= div_q[rtch_pkg::BARY_BITS-1:0];
                        div_sel_reg <= rtch_pkg::DV_V;
                    end
                    default: begin
                        best_v_reg   <= div_q[rtch_pkg::BARY_BITS-1:0];
                        best_tri_reg <= index_reg;
                        any_hit_reg  <= 1'b1;
                        replaced_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            for (int k = 0; k < 3; k++) begin
                e1_reg[k] <= item.vec_b[k];
                e2_reg[k] <= item.vec_c[k];
                tv_reg[k] <= NB'(ray_o_reg[k]) - NB'($signed(item.vec_a[k]));
            end
            index_reg <= item.tri_index;
        end
        if (state_reg == rtch_pkg::ST_MUL_WAIT && mul_done) begin
            case (uop.dst)
                rtch_pkg::W_PV0: pv_reg[0] <= acc_val;
                rtch_pkg::W_PV1: pv_reg[1] <= acc_val;
                rtch_pkg::W_PV2: pv_reg[2] <= acc_val;
                rtch_pkg::W_QV0: qv_reg[0] <= acc_val;
                rtch_pkg::W_QV1: qv_reg[1] <= acc_val;
                rtch_pkg::W_QV2: qv_reg[2] <= acc_val;
                rtch_pkg::W_DET: det_reg   <= acc_val;
                rtch_pkg::W_UN:  un_reg    <= acc_val;
                rtch_pkg::W_VN:  vn_reg    <= acc_val;
                rtch_pkg::W_TN:  tn_reg    <= acc_val;
                default:         lim_reg   <= acc_val;
            endcase
        end
        // A negative determinant flips the whole test so that one-sided checks apply.
        if (state_reg == rtch_pkg::ST_NORM && det_reg[W-1]) begin
            det_reg <= -det_reg;
            un_reg  <= -un_reg;
            vn_reg  <= -vn_reg;
            tn_reg  <= -tn_reg;
        end
        if (ctrl.out_load) begin
            out_data_reg <= rtch_pkg::OUT_TDATA_W'({replaced_reg, best_v_reg, best_u_reg,
                                                    best_dist_reg, best_tri_reg,
                                                    any_hit_reg});
        end
    end

endmodule

// ===== hdl/ray_triangle_closest_hit.sv =====
// Top level of the closest-hit ray/triangle unit.
//
//   Channel   Direction  Signals                         Content
//   s_        in         s_tvalid s_tready s_tdata s_tuser  ray load or triangle test
//   m_        out        m_tvalid m_tready m_tdata          current closest hit
//
// A triangle runs 25 products on the one shift-add multiplier and, if it passes the range
// and limit checks, three quotients on the restoring divider.
// A two-beat input queue keeps taking beats while the sequencer works, until it is full.
// The result register holds a beat until it is taken and stalls only the sequencer.
// Reset clears the ray to zero and the best hit to none.
module ray_triangle_closest_hit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, vec_c_x, vec_c_y,
    // vec_c_z, tri_index, start_limit, zero fill
    input  logic [rtch_pkg::IN_TDATA_W-1:0]   s_tdata,
    // mode
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit_found, hit_triangle, hit_distance, hit_u, hit_v, replaced, zero fill
    output logic [rtch_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    rtch_pkg::item_t item;
    logic            item_valid;
    logic            item_pop;

    rtch_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    rtch_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== hdl/rtch_checker.sv =====
// Port checker for the closest-hit unit and its bind.
module rtch_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rtch_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int BB = rtch_pkg::BARY_BITS;

    logic          found;
    logic          repl;
    logic [BB-1:0] u_val, v_val;
    logic [BB:0]   uv_sum;

    assign found  = m_tdata[rtch_pkg::OUT_FOUND_LSB];
    assign repl   = m_tdata[rtch_pkg::OUT_REPL_LSB];
    assign u_val  = m_tdata[rtch_pkg::OUT_U_LSB +: BB];
    assign v_val  = m_tdata[rtch_pkg::OUT_V_LSB +: BB];
    assign uv_sum = (BB+1)'(u_val) + (BB+1)'(v_val);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_repl_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && repl |-> found)
        else $error("replaced without a hit");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !found |-> m_tdata[rtch_pkg::OUT_TRI_LSB +: rtch_pkg::INDEX_BITS] == '0 &&
                               u_val == '0 && v_val == '0)
        else $error("no hit but hit fields set");

    a_bary_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> uv_sum <= (BB+1)'(1 << rtch_pkg::FRAC_BITS))
        else $error("barycentric sum above one");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result valid or input blocked right after reset");

endmodule

bind ray_triangle_closest_hit rtch_checker u_rtch_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/tb.sv =====
// Self-checking testbench of the closest-hit ray/triangle unit.
module tb;

    typedef logic signed [191:0] wide_t;

    typedef struct packed {
        logic                            found;
        logic [rtch_pkg::INDEX_BITS-1:0] tri_id;
        logic [rtch_pkg::DIST_BITS-1:0]  hit_dist;
        logic [rtch_pkg::BARY_BITS-1:0]  u;
        logic [rtch_pkg::BARY_BITS-1:0]  v;
        logic                            repl;
    } hit_t;

    localparam int LIMIT_CYCLES = 40_000_000;
    localparam logic [31:0] ONE = 32'sh0001_0000;

    logic aclk;
    logic aresetn;
    logic s_tvalid;
    logic s_tready;
    logic [rtch_pkg::IN_TDATA_W-1:0] s_tdata;
    logic s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [rtch_pkg::OUT_TDATA_W-1:0] m_tdata;

    ray_triangle_closest_hit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    logic [2:0][rtch_pkg::COORD_BITS-1:0] ray_org;
    logic [2:0][rtch_pkg::COORD_BITS-1:0] ray_dir;
    logic [rtch_pkg::DIST_BITS-1:0]       best_dist;
    logic [rtch_pkg::INDEX_BITS-1:0]      best_tri;
    logic [rtch_pkg::BARY_BITS-1:0]       best_u;
    logic [rtch_pkg::BARY_BITS-1:0]       best_v;
    logic                                 best_found;

    hit_t expected_hits[$];
    int   errors;
    int   send_idle_pct;
    int   recv_stall_pct;
    longint cycles;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic wide_t sx(logic [rtch_pkg::COORD_BITS-1:0] x);
        return wide_t'(signed'(x));
    endfunction

    function automatic hit_t predict_hit(rtch_pkg::item_t it);
        wide_t o[3], d[3], p[3], e1[3], e2[3], tv[3], pv[3], qv[3];
        wide_t det, un, vn, tn, tsc, lim;
        hit_t r;
        logic repl;
        repl = 1'b0;
        if (it.mode == rtch_pkg::MODE_RAY) begin
            ray_org    = it.vec_a;
            ray_dir    = it.vec_b;
            best_dist  = it.start_limit;
            best_tri   = '0;
            best_u     = '0;
            best_v     = '0;
            best_found = 1'b0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                o[i]  = sx(ray_org[i]);
                d[i]  = sx(ray_dir[i]);
                p[i]  = sx(it.vec_a[i]);
                e1[i] = sx(it.vec_b[i]);
                e2[i] = sx(it.vec_c[i]);
                tv[i] = o[i] - p[i];
            end
            pv[0] = d[1] * e2[2] - d[2] * e2[1];
            pv[1] = d[2] * e2[0] - d[0] * e2[2];
            pv[2] = d[0] * e2[1] - d[1] * e2[0];
            qv[0] = tv[1] * e1[2] - tv[2] * e1[1];
            qv[1] = tv[2] * e1[0] - tv[0] * e1[2];
            qv[2] = tv[0] * e1[1] - tv[1] * e1[0];
            det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
            un  = tv[0] * pv[0] + tv[1] * pv[1] + tv[2] * pv[2];
            vn  = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
            tn  = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
            if (det != 0) begin
                if (det < 0) begin
                    det = -det;
                    un  = -un;
                    vn  = -vn;
                    tn  = -tn;
                end
                tsc = tn <<< rtch_pkg::FRAC_BITS;
                lim = wide_t'({1'b0, best_dist}) * det;
                if (un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn >= 0
                        && tsc <= lim) begin
                    best_dist  = rtch_pkg::DIST_BITS'(tsc / det);
                    best_u     = rtch_pkg::BARY_BITS'((un <<< rtch_pkg::FRAC_BITS) / det);
                    best_v     = rtch_pkg::BARY_BITS'((vn <<< rtch_pkg::FRAC_BITS) / det);
                    best_tri   = it.tri_index;
                    best_found = 1'b1;
                    repl       = 1'b1;
                end
            end
        end
        r.found    = best_found;
        r.tri_id   = best_tri;
        r.hit_dist = best_dist;
        r.u        = best_u;
        r.v        = best_v;
        r.repl     = repl;
        return r;
    endfunction

    always @(posedge aclk) begin
        hit_t want, got;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                got.found    = m_tdata[rtch_pkg::OUT_FOUND_LSB];
                got.tri_id   = m_tdata[rtch_pkg::OUT_TRI_LSB +: rtch_pkg::INDEX_BITS];
                got.hit_dist = m_tdata[rtch_pkg::OUT_DIST_LSB +: rtch_pkg::DIST_BITS];
                got.u        = m_tdata[rtch_pkg::OUT_U_LSB +: rtch_pkg::BARY_BITS];
                got.v        = m_tdata[rtch_pkg::OUT_V_LSB +: rtch_pkg::BARY_BITS];
                got.repl     = m_tdata[rtch_pkg::OUT_REPL_LSB];
                if (expected_hits.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = expected_hits.pop_front();
                    if (got.found !== want.found) begin
                        $display("%0t: hit_found exp %0d got %0d", $time, want.found, got.found);
                        errors++;
                    end
                    if (got.tri_id !== want.tri_id) begin
                        $display("%0t: hit_triangle exp %0d got %0d", $time, want.tri_id,
                                 got.tri_id);
                        errors++;
                    end
                    if (got.hit_dist !== want.hit_dist) begin
                        $display("%0t: hit_distance exp %0d got %0d", $time, want.hit_dist,
                                 got.hit_dist);
                        errors++;
                    end
                    if (got.u !== want.u) begin
                        $display("%0t: hit_u exp %0d got %0d", $time, want.u, got.u);
                        errors++;
                    end
                    if (got.v !== want.v) begin
                        $display("%0t: hit_v exp %0d got %0d", $time, want.v, got.v);
                        errors++;
                    end
                    if (got.repl !== want.repl) begin
                        $display("%0t: replaced exp %0d got %0d", $time, want.repl, got.repl);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic send_item(rtch_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= rtch_pkg::IN_TDATA_W'({it.start_limit, it.tri_index, it.vec_c, it.vec_b,
                                           it.vec_a});
        do @(posedge aclk); while (!s_tready);
        expected_hits.insert(expected_hits.size(), predict_hit(it));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
    endtask

    function automatic rtch_pkg::item_t make_ray(logic [2:0][31:0] o, logic [2:0][31:0] d,
                                                 logic [rtch_pkg::DIST_BITS-1:0] lim);
        rtch_pkg::item_t it;
        it = '0;
        it.mode = rtch_pkg::MODE_RAY;
        it.vec_a = o;
        it.vec_b = d;
        it.vec_c = {$urandom, $urandom, $urandom};
        it.tri_index = rtch_pkg::INDEX_BITS'($urandom);
        it.start_limit = lim;
        return it;
    endfunction

    function automatic rtch_pkg::item_t make_tri(logic [2:0][31:0] p, logic [2:0][31:0] e1,
                                                 logic [2:0][31:0] e2,
                                                 logic [rtch_pkg::INDEX_BITS-1:0] id);
        rtch_pkg::item_t it;
        it = '0;
        it.mode = rtch_pkg::MODE_TRI;
        it.vec_a = p;
        it.vec_b = e1;
        it.vec_c = e2;
        it.tri_index = id;
        it.start_limit = rtch_pkg::DIST_BITS'($urandom);
        return it;
    endfunction

    function automatic logic [31:0] rnd_span(int span);
        return 32'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic rtch_pkg::item_t random_item(logic mode);
        rtch_pkg::item_t it;
        it = ($bits(rtch_pkg::item_t))'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom});
        it.mode = rtch_pkg::mode_t'(mode);
        return it;
    endfunction

    // A triangle placed so that the stored ray crosses it at chosen t, u and v.
    function automatic rtch_pkg::item_t aimed_tri();
        logic [2:0][31:0] p, e1, e2;
        longint t, u, v, hitc;
        t = $urandom_range(4 * 65536);
        u = $urandom_range(65536);
        v = $urandom_range(65536 - u);
        for (int i = 0; i < 3; i++) begin
            e1[i] = rnd_span(1 << 20);
            e2[i] = rnd_span(1 << 20);
            hitc = longint'(signed'(ray_org[i]))
                 + ((longint'(signed'(ray_dir[i])) * t) >>> 16);
            p[i] = 32'(hitc - ((longint'(signed'(e1[i])) * u
                              + longint'(signed'(e2[i])) * v) >>> 16));
        end
        return make_tri(p, e1, e2, rtch_pkg::INDEX_BITS'($urandom));
    endfunction

    task automatic test_extremes();
        logic [2:0][31:0] mn, mx, z;
        mn = {3{32'h8000_0000}};
        mx = {3{32'h7fff_ffff}};
        z  = '0;
        send_item(make_tri(mx, mx, mn, 24'hffffff));
        send_item(make_ray(mn, mx, 31'h7fff_ffff));
        send_item(make_tri(mx, mn, {32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
                           24'hffffff));
        send_item(make_tri(mn, {32'h8000_0000, 32'h7fff_ffff, 32'h0}, mx, 24'h0));
        send_item(make_ray(mx, mn, 31'h0));
        send_item(make_tri(z, mn, mx, 24'h123456));
        send_item(make_ray(z, z, 31'h7fff_ffff));
        send_item(make_tri(z, {32'h0, 32'h0, ONE}, {32'h0, ONE, 32'h0}, 24'h1));
    endtask

    task automatic test_special_cases();
        logic [2:0][31:0] o, d, p, ex, ey;
        o  = '0;
        d  = {ONE, 32'h0, 32'h0};
        ex = {32'h0, 32'h0, ONE};
        ey = {32'h0, ONE, 32'h0};
        send_item(make_ray(o, d, 31'h7fff_ffff));
        p = {32'h5_0000, 32'h0, 32'h0};
        send_item(make_tri(p, ex, ey, 24'h10));
        send_item(make_tri(p, ey, ex, 24'h11));
        send_item(make_tri(p, ex, ey, 24'h12));
        send_item(make_tri({32'h5_0000, 32'h0, 32'hffff_0000}, ex, ey, 24'h13));
        send_item(make_tri({32'h5_0000, 32'hffff_0000, 32'h0}, ex, ey, 24'h14));
        send_item(make_tri({32'h5_0000, 32'hffff_8000, 32'hffff_8000}, ex, ey, 24'h15));
        send_item(make_tri({32'h5_0000, 32'hffff_7fff, 32'hffff_8000}, ex, ey, 24'h16));
        send_item(make_tri({32'h6_0000, 32'h0, 32'h0}, ex, ey, 24'h17));
        send_item(make_tri({32'h4_0000, 32'h0, 32'h0}, ex, ey, 24'h18));
        send_item(make_tri({32'hffff_0000, 32'h0, 32'h0}, ex, ey, 24'h19));
        send_item(make_tri(p, ex, ex, 24'h1a));
        send_item(make_tri(p, {32'h0, ONE, ONE}, ey, 24'h1b));
        send_item(make_ray(o, d, 31'h5_0000));
        send_item(make_tri(p, ex, ey, 24'h1c));
        send_item(make_ray(o, d, 31'h4_ffff));
        send_item(make_tri(p, ex, ey, 24'h1d));
    endtask

    task automatic test_random(int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                logic [2:0][31:0] o, d;
                logic [rtch_pkg::DIST_BITS-1:0] lim;
                for (int i = 0; i < 3; i++) begin
                    o[i] = rnd_span(1 << 22);
                    d[i] = rnd_span(1 << 18);
                end
                lim = ($urandom_range(3) == 0) ?
                      rtch_pkg::DIST_BITS'($urandom_range(4 << 16)) :
                      rtch_pkg::DIST_BITS'($urandom);
                send_item(make_ray(o, d, lim));
                sent++;
                repeat ($urandom_range(12, 2)) begin
                    if ($urandom_range(99) < 85) send_item(aimed_tri());
                    else send_item(random_item(rtch_pkg::MODE_TRI));
                    sent++;
                end
            end else begin
                send_item(random_item($urandom_range(1)));
                sent++;
            end
            if ($urandom_range(99) < 2) wait_drained();
        end
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        best_found = 1'b0;
        best_tri = '0;
        best_dist = '0;
        best_u = '0;
        best_v = '0;
        ray_org = '0;
        ray_dir = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes();
        test_special_cases();
        wait_drained();

        send_idle_pct = 7;
        recv_stall_pct = 61;
        test_random(500);
        send_idle_pct = 61;
        recv_stall_pct = 7;
        test_random(500);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_random(500);

        wait_drained();
        repeat (2000) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
